### design/ocu_pkg.sv
// Shared types, constants and helper functions for the orbit camera update core.
`timescale 1ns / 1ps
package ocu_pkg;

   // Default parameter values
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int POS_FRAC_BITS_DEF = 8;

   // Fixed field widths
   localparam int GAIN_W  = 10;
   localparam int CSR_W   = 21;
   localparam int DIST_W  = 25;
   localparam int DELTA_W = 12;
   localparam int TGT_W   = 24;
   localparam int EYE_W   = 25;
   localparam int Q15_W   = 16;

   // Datapath widths: CORDIC registers and the shared multiplier
   localparam int CW     = 34;
   localparam int MUL_AW = 32;
   localparam int MUL_BW = 26;
   localparam int PW     = MUL_AW + MUL_BW;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032875;
   localparam logic signed [CW-1:0] Z_QUARTER = 34'sh0_4000_0000;
   localparam logic signed [CW-1:0] Z_HALF    = 34'sh0_8000_0000;
   localparam logic signed [PW-1:0] RND_Q15   = 58'sd16384;
   localparam logic signed [PW-1:0] RND_Q30   = 58'sd536870912;

   localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sd32767;
   localparam logic signed [Q15_W-1:0] Q15_MIN = -16'sd32768;

   // Configuration register indexes
   localparam logic CSR_MOUSE_GAIN     = 1'b0;
   localparam logic CSR_ORBIT_DISTANCE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_YAW,
      ST_MUL_PITCH,
      ST_ANG_UPD,
      ST_CORD_SETUP,
      ST_CORD_RUN,
      ST_CORD_DONE,
      ST_PROD
   } ocu_state_type;

   typedef enum logic [2:0] {
      MS_CP_SY,
      MS_CPSY_D,
      MS_CP_CY,
      MS_CPCY_D,
      MS_SP_SY,
      MS_SP_CY,
      MS_SP_D,
      MS_EYE_Y
   } ocu_mstep_type;

   // Arctangent of 2^-i, with 2^32 per turn
   function automatic logic [31:0] ocu_atan(input logic [STEP_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         4'd0:    r = 32'd536870912;
         4'd1:    r = 32'd316933406;
         4'd2:    r = 32'd167458907;
         4'd3:    r = 32'd85004756;
         4'd4:    r = 32'd42667331;
         4'd5:    r = 32'd21354465;
         4'd6:    r = 32'd10679838;
         4'd7:    r = 32'd5340245;
         4'd8:    r = 32'd2670163;
         4'd9:    r = 32'd1335087;
         4'd10:   r = 32'd667544;
         4'd11:   r = 32'd333772;
         4'd12:   r = 32'd166886;
         4'd13:   r = 32'd83443;
         4'd14:   r = 32'd41722;
         default: r = 32'd20861;
      endcase
      return r;
   endfunction

   // Round half up to Q1.15 and saturate
   function automatic logic signed [Q15_W-1:0] ocu_round_q15(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      logic signed [Q15_W-1:0] q;
      r = (v + RND_Q15) >>> 15;
      if (r > PW'(Q15_MAX)) begin
         q = Q15_MAX;
      end else if (r < PW'(Q15_MIN)) begin
         q = Q15_MIN;
      end else begin
         q = r[Q15_W-1:0];
      end
      return q;
   endfunction

endpackage

### design/orbit_camera_update_core.sv
// Orbit camera update core: mode toggle, angle update, sine/cosine and eye/up vectors.
`timescale 1ns / 1ps
// Takes one word per video frame and returns one word with the mode, the angles, the eye
// point and the up vector. A word that leaves orbit mode off is answered in the cycle after it
// is accepted. With orbit mode on, a word goes through the angle update on the shared
// multiplier, two passes of the 16 step CORDIC (pitch, then yaw) and the products on the
// same multiplier; a new word is taken only once the previous result has been taken. After
// reset the core runs both CORDIC passes and the products to build the initial eye point
// and accepts no word meanwhile; configuration writes are taken at any time.
module orbit_camera_update_core
   import ocu_pkg::*;
#(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_toggle_pressed,
   input  logic signed [DELTA_W-1:0] req_mouse_dx,
   input  logic signed [DELTA_W-1:0] req_mouse_dy,
   input  logic signed [TGT_W-1:0]  req_target_x,
   input  logic signed [TGT_W-1:0]  req_target_y,
   input  logic signed [TGT_W-1:0]  req_target_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_orbit_mode,
   output logic signed [15:0]       rsp_pitch_angle,
   output logic signed [15:0]       rsp_yaw_angle,
   output logic signed [EYE_W-1:0]  rsp_eye_x,
   output logic signed [EYE_W-1:0]  rsp_eye_y,
   output logic signed [EYE_W-1:0]  rsp_eye_z,
   output logic signed [Q15_W-1:0]  rsp_up_x,
   output logic signed [Q15_W-1:0]  rsp_up_y,
   output logic signed [Q15_W-1:0]  rsp_up_z,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam longint PITCH_MAG =
      ((longint'(1) << ANGLE_BITS) * 64'sd79577472 + 64'sd500000000) / 64'sd1000000000;
   localparam logic signed [ANGLE_BITS-1:0] PITCH_RST = ANGLE_BITS'(-PITCH_MAG);
   localparam logic signed [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(longint'(1) << (ANGLE_BITS - 2));
   localparam logic signed [ANGLE_BITS-1:0] NEG_QTR = -QTR;
   localparam logic [DIST_W-1:0] DIST_RST = DIST_W'(longint'(200) << POS_FRAC_BITS);
   localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(31);
   localparam int ZSH = 32 - ANGLE_BITS;

   ocu_state_type state_ff, state_in;
   ocu_mstep_type mstep_ff, mstep_in;
   logic init_ff, init_in;
   logic mode_ff, mode_in;
   logic sel_ff, sel_in;
   logic flip_ff, flip_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic signed [ANGLE_BITS-1:0] pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [EYE_W-1:0] eye_x_ff, eye_x_in, eye_y_ff, eye_y_in, eye_z_ff, eye_z_in;
   logic signed [Q15_W-1:0] up_x_ff, up_x_in, up_y_ff, up_y_in, up_z_ff, up_z_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [TGT_W-1:0] tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [Q15_W-1:0] sp_ff, sp_in, cp_ff, cp_in, sy_ff, sy_in, cy_ff, cy_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic req_acc;

   // Per-cycle datapath temporaries
   logic signed [PW-1:0] ang_diff, off30, off15, cs_x, cs_y;
   logic signed [ANGLE_BITS-1:0] ang_wrap, ang_src;
   logic signed [CW-1:0] z_load, x_sh, y_sh, atan_ext;

   assign req_acc = req_valid && !req_stall;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (mode_ff ^ req_toggle_pressed) ? ST_MUL_YAW : ST_IDLE;
            end
         end
         ST_MUL_YAW:    state_in = ST_MUL_PITCH;
         ST_MUL_PITCH:  state_in = ST_ANG_UPD;
         ST_ANG_UPD:    state_in = ST_CORD_SETUP;
         ST_CORD_SETUP: state_in = ST_CORD_RUN;
         ST_CORD_RUN: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_CORD_DONE;
            end
         end
         ST_CORD_DONE:  state_in = sel_ff ? ST_PROD : ST_CORD_SETUP;
         ST_PROD: begin
            if (mstep_ff == MS_EYE_Y) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---------------- handshake outputs ----------------
   // A result word waits in the state registers; rsp_pend marks it.
   logic rsp_pend_ff, rsp_pend_in;

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = rsp_pend_ff;
      rsp_pend_in = rsp_pend_ff;
      unique case (state_ff)
         ST_IDLE: req_stall = rsp_pend_ff;
         default: req_stall = 1'b1;
      endcase
      if (rsp_pend_ff && !rsp_stall) begin
         rsp_pend_in = 1'b0;
      end
      if (state_ff == ST_IDLE && req_acc && !(mode_ff ^ req_toggle_pressed)) begin
         rsp_pend_in = 1'b1;
      end
      if (state_ff == ST_PROD && mstep_ff == MS_EYE_Y && !init_ff) begin
         rsp_pend_in = 1'b1;
      end
   end

   // ---------------- shared multiplier operands ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_YAW: begin
            mul_a = MUL_AW'(dx_ff);
            mul_b = MUL_BW'(signed'({1'b0, gain_ff}));
         end
         ST_MUL_PITCH: begin
            mul_a = MUL_AW'(dy_ff);
            mul_b = MUL_BW'(signed'({1'b0, gain_ff}));
         end
         ST_PROD: begin
            case (mstep_ff)
               MS_CP_SY: begin
                  mul_a = MUL_AW'(cp_ff);
                  mul_b = MUL_BW'(sy_ff);
               end
               MS_CPSY_D, MS_CPCY_D: begin
                  mul_a = p_ff[MUL_AW-1:0];
                  mul_b = MUL_BW'(signed'({1'b0, dist_ff}));
               end
               MS_CP_CY: begin
                  mul_a = MUL_AW'(cp_ff);
                  mul_b = MUL_BW'(cy_ff);
               end
               MS_SP_SY: begin
                  mul_a = MUL_AW'(sp_ff);
                  mul_b = MUL_BW'(sy_ff);
               end
               MS_SP_CY: begin
                  mul_a = MUL_AW'(sp_ff);
                  mul_b = MUL_BW'(cy_ff);
               end
               MS_SP_D: begin
                  mul_a = MUL_AW'(sp_ff);
                  mul_b = MUL_BW'(signed'({1'b0, dist_ff}));
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign p_in = PW'(mul_a) * PW'(mul_b);

   // ---------------- datapath next values ----------------
   always_comb begin
      mode_in  = mode_ff;
      init_in  = init_ff;
      sel_in   = sel_ff;
      flip_in  = flip_ff;
      step_in  = step_ff;
      mstep_in = mstep_ff;
      pitch_in = pitch_ff;
      yaw_in   = yaw_ff;
      eye_x_in = eye_x_ff;
      eye_y_in = eye_y_ff;
      eye_z_in = eye_z_ff;
      up_x_in  = up_x_ff;
      up_y_in  = up_y_ff;
      up_z_in  = up_z_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      tz_in    = tz_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sp_in    = sp_ff;
      cp_in    = cp_ff;
      sy_in    = sy_ff;
      cy_in    = cy_ff;
      gain_in  = gain_ff;
      dist_in  = dist_ff;

      ang_src  = sel_ff ? yaw_ff : pitch_ff;
      ang_diff = PW'(state_ff == ST_MUL_PITCH ? yaw_ff : pitch_ff) - p_ff;
      ang_wrap = ang_diff[ANGLE_BITS-1:0];
      z_load   = CW'(ang_src) <<< ZSH;
      x_sh     = x_ff >>> step_ff;
      y_sh     = y_ff >>> step_ff;
      atan_ext = CW'(ocu_atan(step_ff));
      off30    = (p_ff + RND_Q30) >>> 30;
      off15    = (p_ff + RND_Q15) >>> 15;
      cs_x     = flip_ff ? -PW'(x_ff) : PW'(x_ff);
      cs_y     = flip_ff ? -PW'(y_ff) : PW'(y_ff);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MOUSE_GAIN:     gain_in = csr_wdata[GAIN_W-1:0];
            CSR_ORBIT_DISTANCE: dist_in = DIST_W'(csr_wdata);
            default:            gain_in = gain_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in = mode_ff ^ req_toggle_pressed;
               dx_in   = req_mouse_dx;
               dy_in   = req_mouse_dy;
               tx_in   = req_target_x;
               ty_in   = req_target_y;
               tz_in   = req_target_z;
               sel_in  = 1'b0;
            end
         end
         ST_MUL_PITCH: begin
            // yaw less dx * gain, wrapped to the turn
            yaw_in = ang_wrap;
         end
         ST_ANG_UPD: begin
            if (ang_wrap >= QTR) begin
               pitch_in = QTR;
            end else if (ang_wrap <= NEG_QTR) begin
               pitch_in = NEG_QTR;
            end else begin
               pitch_in = ang_wrap;
            end
         end
         ST_CORD_SETUP: begin
            // fold to within a quarter turn, negate the results at the end
            x_in    = CORDIC_K;
            y_in    = '0;
            step_in = '0;
            if (z_load > Z_QUARTER) begin
               z_in    = z_load - Z_HALF;
               flip_in = 1'b1;
            end else if (z_load < -Z_QUARTER) begin
               z_in    = z_load + Z_HALF;
               flip_in = 1'b1;
            end else begin
               z_in    = z_load;
               flip_in = 1'b0;
            end
         end
         ST_CORD_RUN: begin
            if (z_ff >= 0) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_ext;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_ext;
            end
            step_in = step_ff + STEP_W'(1);
         end
         ST_CORD_DONE: begin
            if (sel_ff) begin
               sy_in = ocu_round_q15(cs_y);
               cy_in = ocu_round_q15(cs_x);
            end else begin
               sp_in = ocu_round_q15(cs_y);
               cp_in = ocu_round_q15(cs_x);
            end
            sel_in   = 1'b1;
            mstep_in = MS_CP_SY;
         end
         ST_PROD: begin
            mstep_in = ocu_mstep_type'(mstep_ff + 3'd1);
            case (mstep_ff)
               MS_CP_CY: begin
                  eye_x_in = EYE_W'(PW'(tx_ff) + off30);
                  if (!init_ff) begin
                     up_y_in = cp_ff;
                  end
               end
               MS_SP_SY: eye_z_in = EYE_W'(PW'(tz_ff) - off30);
               MS_SP_CY: begin
                  if (!init_ff) begin
                     up_x_in = ocu_round_q15(p_ff);
                  end
               end
               MS_SP_D: begin
                  if (!init_ff) begin
                     up_z_in = ocu_round_q15(-p_ff);
                  end
               end
               MS_EYE_Y: begin
                  eye_y_in = EYE_W'(PW'(ty_ff) - off15);
                  init_in  = 1'b0;
               end
               default: init_in = init_ff;
            endcase
         end
         default: init_in = init_ff;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CORD_SETUP;
         init_ff     <= 1'b1;
         rsp_pend_ff <= 1'b0;
         mode_ff     <= 1'b0;
         sel_ff      <= 1'b0;
         mstep_ff    <= MS_CP_SY;
         gain_ff     <= GAIN_RST;
         dist_ff     <= DIST_RST;
         pitch_ff    <= PITCH_RST;
         yaw_ff      <= '0;
         up_x_ff     <= '0;
         up_y_ff     <= Q15_MAX;
         up_z_ff     <= '0;
         tx_ff       <= '0;
         ty_ff       <= '0;
         tz_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         init_ff     <= init_in;
         rsp_pend_ff <= rsp_pend_in;
         mode_ff     <= mode_in;
         sel_ff      <= sel_in;
         mstep_ff    <= mstep_in;
         gain_ff     <= gain_in;
         dist_ff     <= dist_in;
         pitch_ff    <= pitch_in;
         yaw_ff      <= yaw_in;
         up_x_ff     <= up_x_in;
         up_y_ff     <= up_y_in;
         up_z_ff     <= up_z_in;
         tx_ff       <= tx_in;
         ty_ff       <= ty_in;
         tz_ff       <= tz_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff  <= flip_in;
      step_ff  <= step_in;
      eye_x_ff <= eye_x_in;
      eye_y_ff <= eye_y_in;
      eye_z_ff <= eye_z_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      sp_ff    <= sp_in;
      cp_ff    <= cp_in;
      sy_ff    <= sy_in;
      cy_ff    <= cy_in;
      p_ff     <= p_in;
   end

   // ---------------- result word ----------------
   assign rsp_orbit_mode = mode_ff;
   assign rsp_eye_x      = eye_x_ff;
   assign rsp_eye_y      = eye_y_ff;
   assign rsp_eye_z      = eye_z_ff;
   assign rsp_up_x       = up_x_ff;
   assign rsp_up_y       = up_y_ff;
   assign rsp_up_z       = up_z_ff;

   // rescale angles to 65536 per turn
   generate
      if (ANGLE_BITS >= 16) begin : g_ang_wide
         assign rsp_pitch_angle = pitch_ff[ANGLE_BITS-1 -: 16];
         assign rsp_yaw_angle   = yaw_ff[ANGLE_BITS-1 -: 16];
      end else begin : g_ang_narrow
         assign rsp_pitch_angle = {pitch_ff, {(16 - ANGLE_BITS){1'b0}}};
         assign rsp_yaw_angle   = {yaw_ff, {(16 - ANGLE_BITS){1'b0}}};
      end
   endgenerate

   // ---------------- assertions ----------------
   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("input taken while a result word is pending");

   a_mode_toggle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> mode_ff == ($past(mode_ff) ^ $past(req_toggle_pressed)))
      else $error("orbit mode did not follow the toggle");

   a_pitch_clamped: assert property (@(posedge clock) disable iff (reset)
      pitch_ff >= NEG_QTR && pitch_ff <= QTR)
      else $error("pitch outside the quarter turn clamp");

   a_hold_when_off: assert property (@(posedge clock) disable iff (reset)
      req_acc && !(mode_ff ^ req_toggle_pressed) |=>
         $stable(yaw_ff) && $stable(pitch_ff) && $stable(eye_x_ff) && rsp_valid)
      else $error("state changed with orbit mode off");

endmodule
